### sv/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table package
// Beat types, request, result and status codes, and the slot entry layout.
// ----------------------------------------------------------------------------
package stt_pkg;

   // Request codes
   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_RESET  = 3'd1;
   localparam logic [2:0] REQ_REMOVE = 3'd2;
   localparam logic [2:0] REQ_STOP   = 3'd3;
   localparam logic [2:0] REQ_EXEC   = 3'd4;

   // Slot states
   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_STOPPED = 2'd1;
   localparam logic [1:0] ST_ACTIVE  = 2'd2;

   // Repeat modes
   localparam logic [1:0] MODE_ONCE   = 2'd0;
   localparam logic [1:0] MODE_REPEAT = 2'd1;
   localparam logic [1:0] MODE_NOW    = 2'd2;
   localparam logic [1:0] MODE_ONCE_X = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_FIRED   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // Status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_NO_FREE = 2'd1;
   localparam logic [1:0] STS_NOT_USE = 2'd2;

   // Wait reported when nothing is pending
   localparam logic [30:0] NO_WAIT = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] now_ms;
      logic [3:0]  slot;
      logic [30:0] interval_ms;
      logic [1:0]  mode;
      logic [31:0] user_tag;
   } stt_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  result_slot;
      logic [31:0] fired_tag;
      logic [1:0]  status;
      logic [30:0] next_due_ms;
      logic        last;
   } stt_rsp_type;

   // One word of the slot memory
   typedef struct packed {
      logic [31:0] due_time;
      logic [30:0] period;
      logic [1:0]  repeat_mode;
      logic [31:0] tag;
   } stt_entry_type;

endpackage

### sv/software_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table
// Table of timer slots with create, reset, remove, stop and exec scan.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. Due time, period, mode and tag of each
// slot live in a single-port-read synchronous memory with a registered read;
// slot states sit in flip-flops and reset to free. An exec scan reads one slot
// per cycle through that memory port, pausing while a fired result waits on a
// stall of the result side; create searches the slot states one per cycle.
// Fired timers come out in slot order, each as its own beat, followed by the
// scan summary marked last. Due-time compares are unsigned and do not handle
// wrap.
// ----------------------------------------------------------------------------
module software_timer_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stt_pkg::stt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stt_pkg::stt_rsp_type rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1) + 1;

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CREATE  = 3'd1;
   localparam logic [2:0] S_RESET   = 3'd2;
   localparam logic [2:0] S_ACK     = 3'd3;
   localparam logic [2:0] S_SCAN    = 3'd4;
   localparam logic [2:0] S_SUMMARY = 3'd5;

   logic [2:0]               state_ff, state_in;
   stt_pkg::stt_req_type     req_ff, req_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         iss_ff, iss_in;
   logic                     eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]         eval_idx_ff, eval_idx_in;
   logic [30:0]              best_ff, best_in;
   logic [3:0]               ack_slot_ff, ack_slot_in;
   logic [1:0]               ack_status_ff, ack_status_in;
   stt_pkg::stt_rsp_type     rsp_ff, rsp_in;
   logic                     rsp_vld_ff, rsp_vld_in;

   stt_pkg::stt_entry_type   slot_mem_ff [NUM_SLOTS];
   stt_pkg::stt_entry_type   rd_data_ff;
   logic [1:0]               slot_state_ff [NUM_SLOTS];

   // Memory and state-table access strobes
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   stt_pkg::stt_entry_type   wr_data;
   logic                     st_en;
   logic [IDX_W-1:0]         st_idx;
   logic [1:0]               st_val;

   logic                     req_accept;
   logic                     out_free;
   logic                     slot_ok;
   logic                     in_use;
   logic [IDX_W-1:0]         req_idx;
   logic [30:0]              new_period;
   logic                     eval_active;
   logic                     eval_fire;
   logic [31:0]              wait_ms;
   logic                     hold;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_vld_ff || !rsp_stall;
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   // Addressed slot checks
   assign req_idx = IDX_W'(req_data.slot);
   assign slot_ok = (32'(req_data.slot) < 32'(NUM_SLOTS));
   assign in_use  = slot_ok && (slot_state_ff[req_idx] != stt_pkg::ST_FREE);

   // Scan evaluation of the slot held in the read register
   assign eval_active = eval_vld_ff && (slot_state_ff[eval_idx_ff] == stt_pkg::ST_ACTIVE);
   assign eval_fire   = eval_active && (req_ff.now_ms >= rd_data_ff.due_time);
   assign wait_ms     = rd_data_ff.due_time - req_ff.now_ms;
   assign hold        = eval_fire && !out_free;

   // Period after a reset: zero keeps the stored one
   assign new_period = (req_ff.interval_ms != 31'd0) ? req_ff.interval_ms
                                                      : rd_data_ff.period;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      iss_in        = iss_ff;
      eval_vld_in   = eval_vld_ff;
      eval_idx_in   = eval_idx_ff;
      best_in       = best_ff;
      ack_slot_in   = ack_slot_ff;
      ack_status_in = ack_status_ff;
      rsp_in        = rsp_ff;
      rsp_vld_in    = rsp_vld_ff && rsp_stall;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;
      st_en         = 1'b0;
      st_idx        = '0;
      st_val        = stt_pkg::ST_FREE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in        = req_data;
               ack_slot_in   = req_data.slot;
               ack_status_in = stt_pkg::STS_OK;
               unique case (req_data.req_type) inside
                  stt_pkg::REQ_CREATE: begin
                     cnt_in   = '0;
                     state_in = S_CREATE;
                  end
                  stt_pkg::REQ_RESET: begin
                     if (in_use) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_idx;
                        state_in = S_RESET;
                     end else begin
                        ack_status_in = stt_pkg::STS_NOT_USE;
                        state_in      = S_ACK;
                     end
                  end
                  stt_pkg::REQ_REMOVE, stt_pkg::REQ_STOP: begin
                     if (in_use) begin
                        st_en  = 1'b1;
                        st_idx = req_idx;
                        st_val = (req_data.req_type == stt_pkg::REQ_REMOVE) ?
                                 stt_pkg::ST_FREE : stt_pkg::ST_STOPPED;
                     end else begin
                        ack_status_in = stt_pkg::STS_NOT_USE;
                     end
                     state_in = S_ACK;
                  end
                  stt_pkg::REQ_EXEC: begin
                     rd_en       = 1'b1;
                     rd_addr     = '0;
                     eval_vld_in = 1'b1;
                     eval_idx_in = '0;
                     iss_in      = CNT_W'(1);
                     best_in     = stt_pkg::NO_WAIT;
                     state_in    = S_SCAN;
                  end
                  default: begin
                     ack_slot_in   = 4'd0;
                     ack_status_in = stt_pkg::STS_NOT_USE;
                     state_in      = S_ACK;
                  end
               endcase
            end
         end

         // Search the lowest free slot, one per cycle
         S_CREATE: begin
            if (slot_state_ff[cnt_ff] == stt_pkg::ST_FREE) begin
               wr_en               = 1'b1;
               wr_addr             = cnt_ff;
               wr_data.period      = req_ff.interval_ms;
               wr_data.repeat_mode = req_ff.mode;
               wr_data.tag         = req_ff.user_tag;
               wr_data.due_time    = (req_ff.mode == stt_pkg::MODE_NOW) ? req_ff.now_ms :
                                     req_ff.now_ms + {1'b0, req_ff.interval_ms};
               st_en               = 1'b1;
               st_idx              = cnt_ff;
               st_val              = stt_pkg::ST_ACTIVE;
               ack_slot_in         = 4'(cnt_ff);
               ack_status_in       = stt_pkg::STS_OK;
               state_in            = S_ACK;
            end else if (cnt_ff == IDX_W'(NUM_SLOTS - 1)) begin
               ack_slot_in   = 4'd0;
               ack_status_in = stt_pkg::STS_NO_FREE;
               state_in      = S_ACK;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end

         // Write back the reactivated slot
         S_RESET: begin
            wr_en            = 1'b1;
            wr_addr          = IDX_W'(req_ff.slot);
            wr_data.period   = new_period;
            wr_data.due_time = (rd_data_ff.repeat_mode == stt_pkg::MODE_NOW) ?
                               req_ff.now_ms : req_ff.now_ms + {1'b0, new_period};
            st_en            = 1'b1;
            st_idx           = IDX_W'(req_ff.slot);
            st_val           = stt_pkg::ST_ACTIVE;
            state_in         = S_ACK;
         end

         S_ACK: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.result_kind = stt_pkg::KIND_ACK;
               rsp_in.result_slot = ack_slot_ff;
               rsp_in.status      = ack_status_ff;
               rsp_in.last        = 1'b1;
               rsp_vld_in         = 1'b1;
               state_in           = S_IDLE;
            end
         end

         // Evaluate one slot while the next one is read
         S_SCAN: begin
            if (!hold) begin
               if (eval_fire) begin
                  rsp_in             = '0;
                  rsp_in.result_kind = stt_pkg::KIND_FIRED;
                  rsp_in.result_slot = 4'(eval_idx_ff);
                  rsp_in.fired_tag   = rd_data_ff.tag;
                  rsp_vld_in         = 1'b1;
                  if (rd_data_ff.repeat_mode == stt_pkg::MODE_ONCE ||
                      rd_data_ff.repeat_mode == stt_pkg::MODE_ONCE_X) begin
                     st_en  = 1'b1;
                     st_idx = eval_idx_ff;
                     st_val = stt_pkg::ST_FREE;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = eval_idx_ff;
                     wr_data.due_time = req_ff.now_ms + {1'b0, rd_data_ff.period};
                  end
               end else if (eval_active && !wait_ms[31] &&
                            (wait_ms[30:0] < best_ff)) begin
                  best_in = wait_ms[30:0];
               end
               if (iss_ff != CNT_W'(NUM_SLOTS)) begin
                  rd_en       = 1'b1;
                  rd_addr     = iss_ff[IDX_W-1:0];
                  eval_vld_in = 1'b1;
                  eval_idx_in = iss_ff[IDX_W-1:0];
                  iss_in      = iss_ff + CNT_W'(1);
               end else begin
                  eval_vld_in = 1'b0;
                  state_in    = S_SUMMARY;
               end
            end
         end

         S_SUMMARY: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.result_kind = stt_pkg::KIND_SUMMARY;
               rsp_in.next_due_ms = best_ff;
               rsp_in.last        = 1'b1;
               rsp_vld_in         = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         eval_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         eval_vld_ff <= eval_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      cnt_ff        <= cnt_in;
      iss_ff        <= iss_in;
      eval_idx_ff   <= eval_idx_in;
      best_ff       <= best_in;
      ack_slot_ff   <= ack_slot_in;
      ack_status_ff <= ack_status_in;
      rsp_ff        <= rsp_in;
   end

   // Slot states, all free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state_ff[i] <= stt_pkg::ST_FREE;
         end
      end else if (st_en) begin
         slot_state_ff[st_idx] <= st_val;
      end
   end

   // Slot memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

endmodule
